>>> sv/e2q_pkg.sv
// ----------------------------------------------------------------------------
// e2q_pkg
// Widths, fixed-point constants and the arctangent table shared by the
// Euler-to-quaternion pipeline.
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int ANGLE_W      = 16;
  localparam int QUAT_W       = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int XY_W         = 33;
  localparam int Z_W          = 20;
  localparam int TRIG_W       = 22;
  localparam int PAIR_W       = 2 * TRIG_W;
  localparam int HI_W         = 2 * TRIG_W;
  localparam int LO_W         = 2 * TRIG_W + 1;
  localparam int TERM_W       = 66;
  localparam int RES_SHIFT    = 46;
  localparam int RES_W        = TERM_W - RES_SHIFT;

  localparam int LANE_LAT     = CORDIC_STEPS + 2;
  localparam int MUL_LAT      = 5;
  localparam int PIPE_DEPTH   = LANE_LAT + MUL_LAT;

  localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [Z_W-1:0]   PI_Q16      = 20'sd205887;
  localparam logic signed [Z_W-1:0]   PI_HALF_Q16 = 20'sd102944;
  localparam logic signed [RES_W-1:0] Q14_ONE     = 20'sd16384;

  localparam logic signed [Z_W-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
    20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024,  20'sd512,   20'sd256,   20'sd128,  20'sd64,   20'sd32,
    20'sd16,    20'sd8,     20'sd4,     20'sd2
  };

endpackage

>>> sv/e2q_if.sv
// ----------------------------------------------------------------------------
// e2q_if
// Valid/ready channels for Euler angle transactions and quaternion results.
// ----------------------------------------------------------------------------
interface e2q_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [e2q_pkg::ANGLE_W-1:0]        yaw_angle;
  logic signed [e2q_pkg::ANGLE_W-1:0]        pitch_angle;
  logic signed [e2q_pkg::ANGLE_W-1:0]        roll_angle;

  modport source (output valid, yaw_angle, pitch_angle, roll_angle, input ready);
  modport sink   (input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface

interface e2q_out_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [e2q_pkg::QUAT_W-1:0]         quat_w;
  logic signed [e2q_pkg::QUAT_W-1:0]         quat_x;
  logic signed [e2q_pkg::QUAT_W-1:0]         quat_y;
  logic signed [e2q_pkg::QUAT_W-1:0]         quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

>>> sv/euler_to_quaternion.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Yaw, pitch and roll (Q2.13 radians, Z-Y-X order) to a unit quaternion in
// Q1.14, saturated to plus or minus one.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction is accepted every cycle while the pipeline
// advances, and each result passes a fold stage, 16 CORDIC rotation stages
// and a rounding stage per angle, then five multiply and sum stages.
// The pipeline advances whenever the output register is empty or taken;
// otherwise the whole pipeline holds and in_chan.ready is low.
module euler_to_quaternion (
  input logic      clk,
  input logic      rst_n,
  e2q_in_if.sink   in_chan,
  e2q_out_if.source out_chan
);

  localparam int D = e2q_pkg::PIPE_DEPTH;

  logic [D-1:0] vld_r;
  logic         en;

  assign en            = !vld_r[D-1] || out_chan.ready;
  assign in_chan.ready = en;
  assign out_chan.valid = vld_r[D-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[D-2:0], in_chan.valid};
    end
  end

  logic signed [e2q_pkg::TRIG_W-1:0] cy, sy, cp, sp, cr, sr;

  e2q_cordic_lane u_yaw (
    .clk(clk), .en(en), .angle(in_chan.yaw_angle), .cos_q(cy), .sin_q(sy)
  );
  e2q_cordic_lane u_pitch (
    .clk(clk), .en(en), .angle(in_chan.pitch_angle), .cos_q(cp), .sin_q(sp)
  );
  e2q_cordic_lane u_roll (
    .clk(clk), .en(en), .angle(in_chan.roll_angle), .cos_q(cr), .sin_q(sr)
  );

  e2q_quat_mult u_mult (
    .clk(clk), .en(en),
    .cy(cy), .sy(sy), .cp(cp), .sp(sp), .cr(cr), .sr(sr),
    .quat_w(out_chan.quat_w), .quat_x(out_chan.quat_x),
    .quat_y(out_chan.quat_y), .quat_z(out_chan.quat_z)
  );

endmodule

>>> sv/e2q_cordic_lane.sv
// ----------------------------------------------------------------------------
// e2q_cordic_lane
// Cosine and sine of half an angle: fold stage, one register stage per
// CORDIC rotation, then rounding to Q20 with the fold sign applied.
// ----------------------------------------------------------------------------
module e2q_cordic_lane (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [e2q_pkg::ANGLE_W-1:0]  angle,
  output logic signed [e2q_pkg::TRIG_W-1:0]   cos_q,
  output logic signed [e2q_pkg::TRIG_W-1:0]   sin_q
);

  localparam int N = e2q_pkg::CORDIC_STEPS;

  logic signed [e2q_pkg::XY_W-1:0] x_r [N+1];
  logic signed [e2q_pkg::XY_W-1:0] y_r [N+1];
  logic signed [e2q_pkg::Z_W-1:0]  z_r [N+1];
  logic                            flip_r [N+1];

  logic signed [e2q_pkg::Z_W-1:0]  z_in;
  logic signed [e2q_pkg::Z_W-1:0]  z_fold;
  logic                            flip_nxt;
  logic signed [e2q_pkg::XY_W-1:0] x_rnd;
  logic signed [e2q_pkg::XY_W-1:0] y_rnd;
  logic signed [e2q_pkg::TRIG_W-1:0] c_nxt;
  logic signed [e2q_pkg::TRIG_W-1:0] s_nxt;
  logic signed [e2q_pkg::TRIG_W-1:0] cos_r;
  logic signed [e2q_pkg::TRIG_W-1:0] sin_r;

  always_comb begin
    z_in     = e2q_pkg::Z_W'(angle) <<< 2;
    z_fold   = z_in;
    flip_nxt = 1'b0;
    if (z_in > e2q_pkg::PI_HALF_Q16) begin
      z_fold   = z_in - e2q_pkg::PI_Q16;
      flip_nxt = 1'b1;
    end else if (z_in < -e2q_pkg::PI_HALF_Q16) begin
      z_fold   = z_in + e2q_pkg::PI_Q16;
      flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= e2q_pkg::CORDIC_GAIN;
      y_r[0]    <= '0;
      z_r[0]    <= z_fold;
      flip_r[0] <= flip_nxt;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [e2q_pkg::XY_W-1:0] xs;
    logic signed [e2q_pkg::XY_W-1:0] ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        flip_r[i+1] <= flip_r[i];
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - e2q_pkg::ATAN_Q16[i];
        end else begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + e2q_pkg::ATAN_Q16[i];
        end
      end
    end
  end

  always_comb begin
    x_rnd = (x_r[N] + e2q_pkg::XY_W'(512)) >>> 10;
    y_rnd = (y_r[N] + e2q_pkg::XY_W'(512)) >>> 10;
    c_nxt = x_rnd[e2q_pkg::TRIG_W-1:0];
    s_nxt = y_rnd[e2q_pkg::TRIG_W-1:0];
    if (flip_r[N]) begin
      c_nxt = -c_nxt;
      s_nxt = -s_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= c_nxt;
      sin_r <= s_nxt;
    end
  end

  assign cos_q = cos_r;
  assign sin_q = sin_r;

endmodule

>>> sv/e2q_quat_mult.sv
// ----------------------------------------------------------------------------
// e2q_quat_mult
// Triple products and sums for the four quaternion parts: pair products,
// split partial products, term assembly, sum with rounding, saturation.
// ----------------------------------------------------------------------------
module e2q_quat_mult (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [e2q_pkg::TRIG_W-1:0]  cy,
  input  logic signed [e2q_pkg::TRIG_W-1:0]  sy,
  input  logic signed [e2q_pkg::TRIG_W-1:0]  cp,
  input  logic signed [e2q_pkg::TRIG_W-1:0]  sp,
  input  logic signed [e2q_pkg::TRIG_W-1:0]  cr,
  input  logic signed [e2q_pkg::TRIG_W-1:0]  sr,
  output logic signed [e2q_pkg::QUAT_W-1:0]  quat_w,
  output logic signed [e2q_pkg::QUAT_W-1:0]  quat_x,
  output logic signed [e2q_pkg::QUAT_W-1:0]  quat_y,
  output logic signed [e2q_pkg::QUAT_W-1:0]  quat_z
);

  localparam int TW = e2q_pkg::TRIG_W;

  // pair products: 0 cy*cr, 1 sy*sr, 2 cy*sr, 3 sy*cr
  logic signed [e2q_pkg::PAIR_W-1:0] pr_r [4];
  logic signed [TW-1:0]              cp_r;
  logic signed [TW-1:0]              sp_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pr_r[0] <= cy * cr;
      pr_r[1] <= sy * sr;
      pr_r[2] <= cy * sr;
      pr_r[3] <= sy * cr;
      cp_r    <= cp;
      sp_r    <= sp;
    end
  end

  // product k: first term of part k/2 when k even, second when odd
  logic signed [e2q_pkg::PAIR_W-1:0] fa [8];
  logic signed [TW-1:0]              fb [8];

  always_comb begin
    fa[0] = pr_r[0]; fb[0] = cp_r;
    fa[1] = pr_r[1]; fb[1] = sp_r;
    fa[2] = pr_r[2]; fb[2] = cp_r;
    fa[3] = pr_r[3]; fb[3] = sp_r;
    fa[4] = pr_r[0]; fb[4] = sp_r;
    fa[5] = pr_r[1]; fb[5] = cp_r;
    fa[6] = pr_r[3]; fb[6] = cp_r;
    fa[7] = pr_r[2]; fb[7] = sp_r;
  end

  logic signed [e2q_pkg::HI_W-1:0]   hi_r [8];
  logic signed [e2q_pkg::LO_W-1:0]   lo_r [8];
  logic signed [e2q_pkg::TERM_W-1:0] term_r [8];

  for (genvar k = 0; k < 8; k++) begin : g_prod
    logic signed [TW-1:0] fa_hi;
    logic signed [TW:0]   fa_lo;
    assign fa_hi = fa[k][e2q_pkg::PAIR_W-1:TW];
    assign fa_lo = $signed({1'b0, fa[k][TW-1:0]});
    always_ff @(posedge clk) begin
      if (en) begin
        hi_r[k]   <= fa_hi * fb[k];
        lo_r[k]   <= fa_lo * fb[k];
        term_r[k] <= (e2q_pkg::TERM_W'(hi_r[k]) <<< TW) + e2q_pkg::TERM_W'(lo_r[k]);
      end
    end
  end

  localparam logic signed [e2q_pkg::TERM_W-1:0] RND =
    e2q_pkg::TERM_W'(1) <<< (e2q_pkg::RES_SHIFT - 1);

  logic signed [e2q_pkg::TERM_W-1:0] sum_r [4];
  logic signed [e2q_pkg::QUAT_W-1:0] q_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r[0] <= term_r[0] + term_r[1] + RND;
      sum_r[1] <= term_r[2] - term_r[3] + RND;
      sum_r[2] <= term_r[4] + term_r[5] + RND;
      sum_r[3] <= term_r[6] - term_r[7] + RND;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_sat
    logic signed [e2q_pkg::RES_W-1:0]  v;
    logic signed [e2q_pkg::RES_W-1:0]  v_sat;
    always_comb begin
      v = sum_r[k][e2q_pkg::TERM_W-1:e2q_pkg::RES_SHIFT];
      if (v > e2q_pkg::Q14_ONE) begin
        v_sat = e2q_pkg::Q14_ONE;
      end else if (v < -e2q_pkg::Q14_ONE) begin
        v_sat = -e2q_pkg::Q14_ONE;
      end else begin
        v_sat = v;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k] <= v_sat[e2q_pkg::QUAT_W-1:0];
      end
    end
  end

  assign quat_w = q_r[0];
  assign quat_x = q_r[1];
  assign quat_y = q_r[2];
  assign quat_z = q_r[3];

endmodule

>>> verif/e2q_checker.sv
// ----------------------------------------------------------------------------
// e2q_checker
// Watches the angle and quaternion channels, predicts each quaternion from
// the accepted angles with a bit-exact CORDIC model and compares in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module e2q_checker (
  input  logic   clk,
  input  logic   rst_n,
  e2q_in_if      in_chan,
  e2q_out_if     out_chan,
  output int     fail_count,
  output int     pending
);

  typedef struct packed {
    logic signed [e2q_pkg::QUAT_W-1:0] w;
    logic signed [e2q_pkg::QUAT_W-1:0] x;
    logic signed [e2q_pkg::QUAT_W-1:0] y;
    logic signed [e2q_pkg::QUAT_W-1:0] z;
  } quat_t;

  quat_t quat_fifo[$];

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_sh(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic void half_trig(input logic signed [e2q_pkg::ANGLE_W-1:0] ang,
                                    output longint c, output longint s);
    longint z, x, y, xs, ys;
    bit flip;
    z = longint'(ang) * 4;
    flip = 0;
    x = longint'(e2q_pkg::CORDIC_GAIN);
    y = 0;
    if (z > longint'(e2q_pkg::PI_HALF_Q16)) begin
      z -= longint'(e2q_pkg::PI_Q16);
      flip = 1;
    end else if (z < -longint'(e2q_pkg::PI_HALF_Q16)) begin
      z += longint'(e2q_pkg::PI_Q16);
      flip = 1;
    end
    for (int i = 0; i < e2q_pkg::CORDIC_STEPS; i++) begin
      xs = floor_sh(x, i);
      ys = floor_sh(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(e2q_pkg::ATAN_Q16[i]);
      end else begin
        x += ys; y -= xs; z += longint'(e2q_pkg::ATAN_Q16[i]);
      end
    end
    x = round_sh(x, 10);
    y = round_sh(y, 10);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Q60 sums reach about 2^61; 128-bit math keeps them exact.
  function automatic logic signed [e2q_pkg::QUAT_W-1:0] to_q14(
    logic signed [127:0] sum
  );
    logic signed [127:0] v;
    v = (sum + (128'sd1 <<< (e2q_pkg::RES_SHIFT - 1))) >>> e2q_pkg::RES_SHIFT;
    if (v > 128'sd16384) v = 128'sd16384;
    if (v < -128'sd16384) v = -128'sd16384;
    return v[e2q_pkg::QUAT_W-1:0];
  endfunction

  function automatic quat_t euler_to_quat(logic signed [e2q_pkg::ANGLE_W-1:0] yaw,
                                          logic signed [e2q_pkg::ANGLE_W-1:0] pitch,
                                          logic signed [e2q_pkg::ANGLE_W-1:0] roll);
    longint cy, sy, cp, sp, cr, sr;
    logic signed [127:0] a, b, c, d, e, f;
    quat_t q;
    half_trig(yaw, cy, sy);
    half_trig(pitch, cp, sp);
    half_trig(roll, cr, sr);
    a = 128'(cy); b = 128'(sy); c = 128'(cp);
    d = 128'(sp); e = 128'(cr); f = 128'(sr);
    q.w = to_q14(a * e * c + b * f * d);
    q.x = to_q14(a * f * c - b * e * d);
    q.y = to_q14(a * e * d + b * f * c);
    q.z = to_q14(b * e * c - a * f * d);
    return q;
  endfunction

  always @(posedge clk) begin
    quat_t exp_q;
    if (!rst_n) begin
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (in_chan.valid && in_chan.ready)
        quat_fifo.push_back(euler_to_quat(in_chan.yaw_angle, in_chan.pitch_angle,
                                          in_chan.roll_angle));
      if (out_chan.valid && out_chan.ready) begin
        if (quat_fifo.size() == 0) begin
          $display("%0t: unexpected quaternion w=%0d x=%0d y=%0d z=%0d", $time,
                   out_chan.quat_w, out_chan.quat_x, out_chan.quat_y, out_chan.quat_z);
          fail_count <= fail_count + 1;
        end else begin
          exp_q = quat_fifo.pop_front();
          if (exp_q.w !== out_chan.quat_w || exp_q.x !== out_chan.quat_x ||
              exp_q.y !== out_chan.quat_y || exp_q.z !== out_chan.quat_z) begin
            $display("%0t: quaternion mismatch expected w=%0d x=%0d y=%0d z=%0d",
                     $time, exp_q.w, exp_q.x, exp_q.y, exp_q.z);
            $display("%0t:                     actual   w=%0d x=%0d y=%0d z=%0d",
                     $time, out_chan.quat_w, out_chan.quat_x, out_chan.quat_y,
                     out_chan.quat_z);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= quat_fifo.size();
    end
  end

endmodule

>>> verif/tb_euler_to_quaternion.sv
// ----------------------------------------------------------------------------
// tb_euler_to_quaternion
// Drives angle transactions (directed corners, then random) through phases of
// sender and receiver idling, with a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_euler_to_quaternion;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = e2q_pkg::PIPE_DEPTH + 10;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   send_idle_pct;
  int   recv_stall_pct;
  bit   hold_off;
  bit   done;
  int   cycle_count;

  e2q_in_if  in_chan ();
  e2q_out_if out_chan ();

  euler_to_quaternion DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  e2q_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("euler_to_quaternion test failed");
        $finish;
      end
    end
  end

  // receiver: random stalls, or a long hold-off
  initial begin
    out_chan.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_off)
        out_chan.ready <= 0;
      else
        out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_angles(logic [e2q_pkg::ANGLE_W-1:0] yaw,
                             logic [e2q_pkg::ANGLE_W-1:0] pitch,
                             logic [e2q_pkg::ANGLE_W-1:0] roll);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 0;
      @(negedge clk);
    end
    in_chan.valid       <= 1;
    in_chan.yaw_angle   <= yaw;
    in_chan.pitch_angle <= pitch;
    in_chan.roll_angle  <= roll;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [e2q_pkg::ANGLE_W-1:0] rand_angle();
    case ($urandom_range(5))
      0:       return $urandom_range(3) == 0 ? 16'h8000 : 16'h7FFF;
      1:       return 16'($signed($urandom_range(1000)) - 500);
      2:       return 16'($urandom_range(25736 + 200, 25736 - 200));
      3:       return 16'(-$signed($urandom_range(25736 + 200, 25736 - 200)));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [e2q_pkg::ANGLE_W-1:0] corners[10];
    corners = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF,
                16'd12868, -16'sd12868, 16'd25736, -16'sd25736, 16'h5555};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off       = 0;
    rst_n          = 0;
    in_chan.valid  = 0;
    in_chan.yaw_angle   = 0;
    in_chan.pitch_angle = 0;
    in_chan.roll_angle  = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    for (int i = 0; i < 10; i++)
      send_angles(corners[i], corners[(i + 3) % 10], corners[(i + 7) % 10]);
    for (int i = 0; i < 10; i++)
      send_angles(corners[i], corners[i], corners[i]);
    send_angles(16'hAAAA, 16'h5555, 16'h0F0F);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1 || phase == 3) ? (phase == 1 ? 53 : 21) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 53 : 21) : 0;
      if (phase == 0) begin
        fork
          begin
            hold_off = 1;
            repeat (200) @(negedge clk);
            hold_off = 0;
          end
          for (int i = 0; i < 60; i++)
            send_angles(rand_angle(), rand_angle(), rand_angle());
        join
      end
      for (int i = 0; i < 260; i++)
        send_angles(rand_angle(), rand_angle(), rand_angle());
      if (phase == 1) begin
        in_chan.valid <= 0;
        wait_drained();
      end
    end

    recv_stall_pct = 0;
    in_chan.valid <= 0;
    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("euler_to_quaternion test passed");
    else
      $display("euler_to_quaternion test failed");
    $finish;
  end

endmodule
